[rtl/core/ebfp_pkg.sv]
// ----------------------------------------------------------------------------
// ebfp_pkg
// Shared types and constants of the escaped byte frame packer.
// ----------------------------------------------------------------------------
package ebfp_pkg;

    localparam int          SLOT_MAX = 8;
    localparam logic [7:0]  ESC_BYTE = 8'h7d;
    localparam logic [7:0]  INS_BYTE = 8'h82;
    localparam logic [7:0]  PAD_BYTE = 8'h00;
    localparam int          Q_DEPTH  = 2;

    // One classified source byte on its way from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       ins;   // place an escape filler ahead of data
        logic       last;  // final source byte of the message
    } ebfp_entry_t;

    typedef struct packed {
        logic [1:0] count;
        logic       full;
        logic       empty;
    } ebfp_q_stat_t;

    typedef struct packed {
        logic load;       // a frame enters the output register
        logic load_last;  // and it closes the message
        logic fill_zero;  // no bytes pending in the open frame
        logic pop;        // the head entry is retired
    } ebfp_back_stat_t;

endpackage

[rtl/core/ebfp_front.sv]
// ----------------------------------------------------------------------------
// ebfp_front
// Accepts source bytes, tracks the message position and flags each byte
// for escape filler insertion and end of message.
// ----------------------------------------------------------------------------
module ebfp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic [15:0]          msg_length,
    output logic                 push,
    output ebfp_pkg::ebfp_entry_t push_entry
);
    import ebfp_pkg::*;

    logic [15:0] index_reg, index_next;
    logic        prev_esc_reg, prev_esc_next;
    logic        is_last;
    logic        is_ins;

    always_comb begin
        is_last = ({1'b0, index_reg} + 17'd1) >= {1'b0, msg_length};
        is_ins  = prev_esc_reg && (index_reg >= 16'd3)
                  && (({2'b00, index_reg} + 18'd2) <= {2'b00, msg_length});
        // zero-length beats are taken and dropped
        push    = in_valid && in_ready && (msg_length != 16'd0);

        push_entry.data = data_byte;
        push_entry.ins  = is_ins;
        push_entry.last = is_last;

        index_next    = index_reg;
        prev_esc_next = prev_esc_reg;
        if (push) begin
            if (is_last) begin
                index_next    = 16'd0;
                prev_esc_next = 1'b0;
            end else begin
                index_next    = index_reg + 16'd1;
                prev_esc_next = (data_byte == ESC_BYTE);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg    <= 16'd0;
            prev_esc_reg <= 1'b0;
        end else begin
            index_reg    <= index_next;
            prev_esc_reg <= prev_esc_next;
        end
    end

endmodule

[rtl/core/ebfp_queue.sv]
// ----------------------------------------------------------------------------
// ebfp_queue
// Two-entry queue that decouples the classifier from the frame builder.
// ----------------------------------------------------------------------------
module ebfp_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ebfp_pkg::ebfp_entry_t push_entry,
    input  logic                  pop,
    output ebfp_pkg::ebfp_entry_t head,
    output ebfp_pkg::ebfp_q_stat_t stat
);
    import ebfp_pkg::*;

    ebfp_entry_t mem [Q_DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    always_comb begin
        head       = mem[rd_ptr_reg];
        stat.count = count_reg;
        stat.full  = (count_reg == 2'(Q_DEPTH));
        stat.empty = (count_reg == 2'd0);

        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/ebfp_back.sv]
// ----------------------------------------------------------------------------
// ebfp_back
// Places one byte per cycle into the open frame, stalling while a due frame
// waits on a held output register, and hands full or final frames to it.
// ----------------------------------------------------------------------------
module ebfp_back #(
    parameter int FRAME_BYTES = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     head_valid,
    input  ebfp_pkg::ebfp_entry_t    head,
    output ebfp_pkg::ebfp_back_stat_t stat,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [7:0]               out_bytes [ebfp_pkg::SLOT_MAX],
    output logic                     out_last
);
    import ebfp_pkg::*;

    localparam int FILL_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

    logic [7:0]        slots_reg [FRAME_BYTES];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              phase_reg, phase_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_bytes_reg [SLOT_MAX];
    logic              out_last_reg;

    logic [7:0]        place_byte;
    logic              place_last;
    logic              filler_step;
    logic [FILL_W:0]   fill_inc;
    logic              emit;
    logic              fire;
    logic              pop;
    logic [7:0]        frame_w [SLOT_MAX];

    always_comb begin
        filler_step = head.ins && !phase_reg;
        place_byte  = filler_step ? INS_BYTE : head.data;
        place_last  = filler_step ? 1'b0 : head.last;
        fill_inc    = {1'b0, fill_reg} + {{FILL_W{1'b0}}, 1'b1};
        emit        = (fill_inc >= (FILL_W+1)'(FRAME_BYTES)) || place_last;
        // stall only when a frame must go out and the output is still held
        fire        = head_valid && (!emit || !out_valid_reg || out_ready);
        pop         = fire && !filler_step;

        for (int j = 0; j < SLOT_MAX; j++) begin
            if (j < FRAME_BYTES && j < int'(fill_reg)) begin
                frame_w[j] = slots_reg[j];
            end else if (j < FRAME_BYTES && j == int'(fill_reg)) begin
                frame_w[j] = place_byte;
            end else begin
                frame_w[j] = PAD_BYTE;
            end
        end

        fill_next  = fill_reg;
        phase_next = phase_reg;
        if (fire) begin
            fill_next  = emit ? '0 : fill_inc[FILL_W-1:0];
            phase_next = filler_step;
        end

        out_valid_next = (fire && emit) || (out_valid_reg && !out_ready);

        stat.load      = fire && emit;
        stat.load_last = fire && emit && place_last;
        stat.fill_zero = (fill_reg == '0);
        stat.pop       = pop;
    end

    always_ff @(posedge aclk) begin
        if (fire && !emit) begin
            slots_reg[fill_reg] <= place_byte;
        end
        if (fire && emit) begin
            out_bytes_reg <= frame_w;
            out_last_reg  <= place_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_bytes = out_bytes_reg;
    assign out_last  = out_last_reg;

endmodule

[rtl/core/escaped_byte_frame_packer.sv]
// ----------------------------------------------------------------------------
// A completing beat goes into the queue, then its frame into the output
// register behind m_valid, after a filler step if that byte needs one.
// Throughput: 1 source beat per cycle while the queue has room; a byte that
// needs an escape filler holds the frame builder for an extra step, which
// fills the 2-entry queue and drops s_ready at full rate.
// Reset: aresetn low clears the message position, escape flag, open frame
// fill, queue and output valid; the block takes beats once aresetn is high.
// ----------------------------------------------------------------------------
// escaped_byte_frame_packer
// Packs message bytes into fixed frames, inserting an escape filler after
// mid-message 0x7d bytes and padding the final frame.
// ----------------------------------------------------------------------------
module escaped_byte_frame_packer #(
    parameter int FRAME_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [15:0] s_msg_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte0,
    output logic [7:0]  m_byte1,
    output logic [7:0]  m_byte2,
    output logic [7:0]  m_byte3,
    output logic [7:0]  m_byte4,
    output logic [7:0]  m_byte5,
    output logic [7:0]  m_byte6,
    output logic [7:0]  m_byte7,
    output logic        m_last_frame
);
    import ebfp_pkg::*;

    logic            push;
    ebfp_entry_t     push_entry;
    ebfp_entry_t     head;
    ebfp_q_stat_t    q_stat;
    ebfp_back_stat_t back_stat;
    logic [7:0]      frame_bytes [SLOT_MAX];

    assign s_ready = !q_stat.full;

    ebfp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .data_byte  (s_data_byte),
        .msg_length (s_msg_length),
        .push       (push),
        .push_entry (push_entry)
    );

    ebfp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (back_stat.pop),
        .head       (head),
        .stat       (q_stat)
    );

    ebfp_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (!q_stat.empty),
        .head       (head),
        .stat       (back_stat),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_bytes  (frame_bytes),
        .out_last   (m_last_frame)
    );

    assign m_byte0 = frame_bytes[0];
    assign m_byte1 = frame_bytes[1];
    assign m_byte2 = frame_bytes[2];
    assign m_byte3 = frame_bytes[3];
    assign m_byte4 = frame_bytes[4];
    assign m_byte5 = frame_bytes[5];
    assign m_byte6 = frame_bytes[6];
    assign m_byte7 = frame_bytes[7];

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= 2'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_last_clears_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.load_last |=> back_stat.fill_zero)
        else $error("open frame not empty after final frame");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !back_stat.load)
        else $error("frame loaded over a waiting frame");

endmodule

[dv/tb_escaped_byte_frame_packer.sv]
// ----------------------------------------------------------------------------
// tb_escaped_byte_frame_packer
// Streams directed and random messages into the frame packer and checks each
// emitted frame, slot by slot, against a packing model kept by the bench.
// ----------------------------------------------------------------------------

module tb_escaped_byte_frame_packer;
    import ebfp_pkg::*;

    localparam int FRAME_BYTES = 8;
    localparam int RANDOM_BYTES = 1900;

    typedef struct packed {
        logic [7:0][7:0] slots;
        logic            last;
    } frame_t;

    class frame_tracker;
        logic [7:0]  open_slots [SLOT_MAX];
        int          fill;
        int unsigned next_index;
        bit          after_escape;
        frame_t      frames_due [$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            foreach (open_slots[i]) open_slots[i] = PAD_BYTE;
            fill         = 0;
            next_index   = 0;
            after_escape = 1'b0;
        endfunction

        // Place one byte in the open frame; close the frame when full or final.
        function void place(logic [7:0] b, bit closing);
            frame_t f;
            open_slots[fill] = b;
            fill++;
            if (fill >= FRAME_BYTES || closing) begin
                foreach (open_slots[i]) f.slots[i] = open_slots[i];
                f.last = closing;
                frames_due.push_back(f);
                foreach (open_slots[i]) open_slots[i] = PAD_BYTE;
                fill = 0;
            end
        endfunction

        // Note an accepted source beat and queue the frames it completes.
        function void take_byte(logic [7:0] data, logic [15:0] len);
            int unsigned k;
            bit          closing;
            if (len == 16'd0)
                return;
            k       = next_index;
            closing = (k + 1 >= len);
            // Escape filler only away from both ends of the message
            if (after_escape && k >= 3 && k + 2 <= len)
                place(INS_BYTE, 1'b0);
            after_escape = (data == ESC_BYTE);
            place(data, closing);
            if (closing)
                restart();
            else
                next_index = k + 1;
        endfunction

        function void check_frame(frame_t got);
            frame_t want;
            if (frames_due.size() == 0) begin
                $display("%0t: unexpected frame: expected none, actual %h last %b",
                         $time, got.slots, got.last);
                errors++;
                return;
            end
            want = frames_due.pop_front();
            for (int i = 0; i < SLOT_MAX; i++) begin
                if (got.slots[i] !== want.slots[i]) begin
                    $display("%0t: byte%0d mismatch: expected %h, actual %h",
                             $time, i, want.slots[i], got.slots[i]);
                    errors++;
                end
            end
            if (got.last !== want.last) begin
                $display("%0t: last_frame mismatch: expected %b, actual %b",
                         $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte  = 8'h00;
    logic [15:0] s_msg_length = 16'h0000;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [7:0]  m_byte0, m_byte1, m_byte2, m_byte3;
    logic [7:0]  m_byte4, m_byte5, m_byte6, m_byte7;
    logic        m_last_frame;

    int send_idle = 23;
    int recv_idle = 73;
    int bytes_taken = 0;

    frame_tracker sb = new();

    escaped_byte_frame_packer #(
        .FRAME_BYTES (FRAME_BYTES)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_msg_length (s_msg_length),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_byte0      (m_byte0),
        .m_byte1      (m_byte1),
        .m_byte2      (m_byte2),
        .m_byte3      (m_byte3),
        .m_byte4      (m_byte4),
        .m_byte5      (m_byte5),
        .m_byte6      (m_byte6),
        .m_byte7      (m_byte7),
        .m_last_frame (m_last_frame)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge aclk) begin
        frame_t got;
        if (aresetn && m_valid && m_ready) begin
            got.slots = {m_byte7, m_byte6, m_byte5, m_byte4,
                         m_byte3, m_byte2, m_byte1, m_byte0};
            got.last  = m_last_frame;
            sb.check_frame(got);
        end
    end

    // Bias toward the escape byte so fillers show up often
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 2) == 0)
            return ESC_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_beat(input logic [7:0] data, input logic [15:0] len);
        if (bytes_taken < RANDOM_BYTES / 3) begin
            send_idle = 23;
            recv_idle = 73;
        end else if (bytes_taken < 2 * RANDOM_BYTES / 3) begin
            send_idle = 73;
            recv_idle = 23;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= data;
        s_msg_length <= len;
        do @(posedge aclk); while (!s_ready);
        sb.take_byte(data, len);
        if (len != 16'd0)
            bytes_taken++;
    endtask

    // Hold the sender off until every queued frame has come out.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.frames_due.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        logic [7:0]  esc_run [8];
        logic [7:0]  spill   [9];
        int          kind;
        int          len;
        int          n;
        logic [15:0] wide_len;

        esc_run = '{8'h7d, 8'h7d, 8'h7d, 8'h7d,
                    8'h00, 8'hff, 8'h7d, 8'h7d};
        spill   = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55,
                    8'h66, 8'h7d, 8'h00, 8'hff};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Zero length is dropped; a one-byte message is a single padded frame
        send_beat(8'h5a, 16'd0);
        send_beat(8'hff, 16'd1);
        // Escape runs at the message head, middle and tail; fillers spill past one frame
        foreach (esc_run[i]) send_beat(esc_run[i], 16'd8);
        // Length shrinks mid-message: the beat with the short length closes it
        send_beat(8'ha5, 16'hffff);
        send_beat(8'h5a, 16'hffff);
        send_beat(8'h7d, 16'hffff);
        send_beat(8'h7d, 16'd2);
        // Filler lands in the last slot and spills the byte into a new frame
        foreach (spill[i]) send_beat(spill[i], 16'd9);
        drain();

        while (bytes_taken < RANDOM_BYTES) begin
            kind = $urandom_range(0, 99);
            if (kind < 5) begin
                send_beat(pick_byte(), 16'd0);
            end else if (kind < 12) begin
                // Broken message: wide length, then cut short
                wide_len = 16'($urandom);
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_beat(pick_byte(),
                              ($urandom_range(0, 4) == 0) ? 16'd0 : wide_len);
                send_beat(pick_byte(), 16'($urandom_range(1, n)));
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 70)
                                                  : $urandom_range(1, 24);
                for (int i = 0; i < len; i++)
                    send_beat(pick_byte(), 16'(len));
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/core/ebfp_pkg.sv
rtl/core/ebfp_front.sv
rtl/core/ebfp_queue.sv
rtl/core/ebfp_back.sv
rtl/core/escaped_byte_frame_packer.sv
dv/tb_escaped_byte_frame_packer.sv
